/* hdl/rlbc_pkg.sv */
// Shared types, mode codes and arithmetic helpers for the RGBA layer blend compositor.
package rlbc_pkg;

    localparam logic [3:0] ModeAdd      = 4'd0;
    localparam logic [3:0] ModeSub      = 4'd1;
    localparam logic [3:0] ModeDiff     = 4'd2;
    localparam logic [3:0] ModeDarken   = 4'd3;
    localparam logic [3:0] ModeLighten  = 4'd4;
    localparam logic [3:0] ModeMult     = 4'd5;
    localparam logic [3:0] ModeBlend    = 4'd6;
    localparam logic [3:0] ModeScreen   = 4'd7;
    localparam logic [3:0] ModeGmerge   = 4'd8;
    localparam logic [3:0] ModeGextract = 4'd9;
    localparam logic [3:0] ModeDivide   = 4'd10;
    localparam logic [3:0] ModeDodge    = 4'd11;

    localparam logic [7:0] CfgMode  = 8'd0;
    localparam logic [7:0] CfgBlend = 8'd1;

    localparam int NumChan          = 3;
    localparam int DivBits          = 8;
    localparam int DivStepsPerStage = 2;
    localparam int NumDivStages     = DivBits / DivStepsPerStage - 1;

    localparam logic [15:0] RoundBias = 16'h0080;
    localparam logic [15:0] BlendBias = 16'h0001;
    localparam logic [8:0]  GrainBias = 9'd128;
    localparam logic [8:0]  GrainHigh = 9'd383;
    localparam logic [8:0]  DivBase   = 9'd256;
    localparam logic [7:0]  PixMax    = 8'hff;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] blend_amount;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  simple;
        logic [15:0] prod;
        logic [8:0]  divisor;
        logic        sat;
        logic [7:0]  rem;
        logic [7:0]  quot;
    } chan_t;

    typedef struct packed {
        chan_t [NumChan-1:0] ch;
        logic [7:0]          alpha_min;
        logic [15:0]         alpha_prod;
        logic [3:0]          mode;
        logic                last;
    } pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } out_t;

    // One restoring step of the quotient; the remainder always stays below the divisor.
    function automatic chan_t div_step(chan_t c);
        logic [8:0] r2;
        chan_t      n;
        n  = c;
        r2 = {c.rem, 1'b0};
        if (r2 >= c.divisor)
        begin
            n.rem  = 8'(r2 - c.divisor);
            n.quot = {c.quot[6:0], 1'b1};
        end
        else
        begin
            n.rem  = r2[7:0];
            n.quot = {c.quot[6:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic [7:0] round8(logic [15:0] t);
        logic [16:0] u;
        u = {1'b0, t} + {9'd0, t[15:8]};
        return u[15:8];
    endfunction

endpackage

/* hdl/rlbc_prep.sv */
// First pipeline stage: simple channel operations, products and divider set-up.
module rlbc_prep
    import rlbc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [3:0][7:0] a_px,
    input  logic [3:0][7:0] b_px,
    input  logic            in_last,
    output logic            out_valid,
    input  logic            out_ready,
    output pix_t            out_pix
);

    function automatic chan_t chan_prep(logic [7:0] x, logic [7:0] y, cfg_t c);
        logic [8:0] sum;
        logic [8:0] xb;
        logic [8:0] g;
        logic [7:0] mx;
        logic [7:0] my;
        logic [7:0] winv;
        chan_t      r;
        sum  = {1'b0, x} + {1'b0, y};
        xb   = {1'b0, x} + GrainBias;
        g    = xb - {1'b0, y};
        winv = ~c.blend_amount;
        case (c.mode)
            ModeAdd:      r.simple = sum[8] ? PixMax : sum[7:0];
            ModeSub:      r.simple = (x > y) ? x - y : 8'd0;
            ModeDiff:     r.simple = (x > y) ? x - y : y - x;
            ModeDarken:   r.simple = (x < y) ? x : y;
            ModeLighten:  r.simple = (x > y) ? x : y;
            ModeGmerge:
            begin
                if (sum < GrainBias)
                    r.simple = 8'd0;
                else if (sum > GrainHigh)
                    r.simple = PixMax;
                else
                    r.simple = 8'(sum - GrainBias);
            end
            ModeGextract:
            begin
                if (xb < {1'b0, y})
                    r.simple = 8'd0;
                else
                    r.simple = g[8] ? PixMax : g[7:0];
            end
            default:      r.simple = 8'd0;
        endcase
        mx = (c.mode == ModeScreen) ? ~x : x;
        my = (c.mode == ModeScreen) ? ~y : y;
        if (c.mode == ModeBlend)
            r.prod = 16'(x) * 16'(winv) + 16'(y) * 16'(c.blend_amount) + BlendBias;
        else
            r.prod = 16'(mx) * 16'(my) + RoundBias;
        if (c.mode == ModeDodge)
            r.divisor = DivBase - {1'b0, y};
        else
            r.divisor = {1'b0, y} + 9'd1;
        r.sat  = ({1'b0, x} >= r.divisor);
        r.rem  = r.sat ? 8'd0 : x;
        r.quot = 8'd0;
        return r;
    endfunction

    logic valid_reg;
    pix_t data_reg;
    pix_t data_next;
    logic [7:0] winv;

    assign winv = ~cfg.blend_amount;

    always_comb
    begin
        for (int i = 0; i < NumChan; i++)
        begin
            data_next.ch[i] = chan_prep(a_px[i], b_px[i], cfg);
        end
        data_next.alpha_min  = (a_px[3] < b_px[3]) ? a_px[3] : b_px[3];
        data_next.alpha_prod = 16'(a_px[3]) * 16'(winv)
                             + 16'(b_px[3]) * 16'(cfg.blend_amount) + BlendBias;
        data_next.mode       = cfg.mode;
        data_next.last       = in_last;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pix   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/rlbc_div_stage.sv */
// Middle pipeline stage: advances the three channel quotients by a fixed number of steps.
module rlbc_div_stage
    import rlbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_pix,
    output logic out_valid,
    input  logic out_ready,
    output pix_t out_pix
);

    logic valid_reg;
    pix_t data_reg;
    pix_t data_next;

    always_comb
    begin
        data_next = in_pix;
        for (int i = 0; i < NumChan; i++)
        begin
            for (int k = 0; k < DivStepsPerStage; k++)
            begin
                data_next.ch[i] = div_step(data_next.ch[i]);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pix   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/rlbc_finish.sv */
// Last pipeline stage: final quotient steps, rounding, mode selection and output register.
module rlbc_finish
    import rlbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pix_t in_pix,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_px
);

    function automatic logic [7:0] chan_sel(chan_t c, logic [3:0] mode);
        logic [7:0] r;
        case (mode)
            ModeAdd, ModeSub, ModeDiff, ModeDarken, ModeLighten, ModeGmerge, ModeGextract:
                r = c.simple;
            ModeMult, ModeBlend:
                r = round8(c.prod);
            ModeScreen:
                r = ~round8(c.prod);
            ModeDivide, ModeDodge:
                r = c.sat ? PixMax : c.quot;
            default:
                r = 8'd0;
        endcase
        return r;
    endfunction

    logic valid_reg;
    out_t data_reg;
    out_t data_next;
    pix_t pix;

    always_comb
    begin
        pix = in_pix;
        for (int i = 0; i < NumChan; i++)
        begin
            for (int k = 0; k < DivStepsPerStage; k++)
            begin
                pix.ch[i] = div_step(pix.ch[i]);
            end
        end
        data_next.red   = chan_sel(pix.ch[0], pix.mode);
        data_next.green = chan_sel(pix.ch[1], pix.mode);
        data_next.blue  = chan_sel(pix.ch[2], pix.mode);
        if (pix.mode == ModeBlend)
            data_next.alpha = round8(pix.alpha_prod);
        else if (pix.mode > ModeDodge)
            data_next.alpha = 8'd0;
        else
            data_next.alpha = pix.alpha_min;
        data_next.last = pix.last;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_px    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/rgba_layer_blend_compositor.sv */
// Top level of the RGBA layer blend compositor: configuration registers and the stage chain.
//
//  Channel  | Direction | Handshake            | Contents
//  ---------+-----------+----------------------+-------------------------------------------
//  s_*      | in        | s_tvalid / s_tready  | pixel pair from layers a and b, tlast
//  m_*      | out       | m_tvalid / m_tready  | composited pixel, tlast
//  cfg_*    | in        | cfg_valid / cfg_ready| register index and write data
//
// One word enters per cycle unless a stalled output backs up; the eight quotient steps of
// divide and dodge run two per stage over four stages after the preparation stage.
// Reset clears the stage valid bits and sets mode and blend_amount to zero.
// A stalled output holds its word while earlier stages keep filling any empty slots.
// Configuration writes are always accepted.
module rgba_layer_blend_compositor
    import rlbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // d_red, d_green, d_blue, d_alpha
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [3:0][7:0] a_px;
    logic [3:0][7:0] b_px;

    pix_t                stg_pix   [NumDivStages+1];
    logic [NumDivStages:0] stg_valid;
    logic [NumDivStages:0] stg_ready;

    out_t out_px;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CfgMode:  cfg_next.mode         = cfg_data[3:0];
                CfgBlend: cfg_next.blend_amount = cfg_data;
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_px[i] = s_tdata[8*i +: 8];
            b_px[i] = s_tdata[32 + 8*i +: 8];
        end
    end

    rlbc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_px      (a_px),
        .b_px      (b_px),
        .in_last   (s_tlast),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_pix   (stg_pix[0])
    );

    for (genvar k = 0; k < NumDivStages; k++)
    begin : g_div
        rlbc_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_pix    (stg_pix[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_pix   (stg_pix[k+1])
        );
    end

    rlbc_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[NumDivStages]),
        .in_ready  (stg_ready[NumDivStages]),
        .in_pix    (stg_pix[NumDivStages]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_px    (out_px)
    );

    assign m_tdata = {out_px.alpha, out_px.blue, out_px.green, out_px.red};
    assign m_tlast = out_px.last;

endmodule

/* hdl/rlbc_checker.sv */
// Port-level assertions for the RGBA layer blend compositor and their bind.
module rlbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // The input side can only be blocked by a stalled output.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked although the output is not stalled");

    // With the output draining, an accepted word reaches the output once it has passed every stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && (m_tlast == $past(s_tlast, 5)))
        else $error("accepted word did not appear after the pipeline latency");

endmodule

bind rgba_layer_blend_compositor rlbc_checker u_rlbc_checker (.*);

/* verif/rgba_layer_blend_compositor_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RGBA layer blend compositor: directed corners, then random mode phases.
module rgba_layer_blend_compositor_tb;
    import rlbc_pkg::*;

    localparam int StallLimit  = 1000;
    localparam int ReportLimit = 100;
    localparam int RandomItems = 1200;
    localparam int SteadyItems = 100;

    localparam logic [3:0] ModeFirstUnused = ModeDodge + 4'd1;
    localparam logic [3:0] ModeLastUnused  = 4'hf;
    localparam logic [7:0] CfgFirstUnused  = CfgBlend + 8'd1;

    // Pixel pairs are written as {b, a}, each channel set as alpha, blue, green, red.
    localparam logic [63:0] CornerPair = {32'h0000ffff, 32'hff00ff00};
    localparam logic [63:0] MixedPair  = {32'hc8805a00, 32'h2580c8ff};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;

    out_t       expected_pixels[$];
    logic [3:0] model_mode    = ModeAdd;
    logic [7:0] model_weight  = 8'd0;
    bit [15:0]  modes_seen    = '0;
    int         error_count   = 0;
    int         pixels_in     = 0;
    int         pixels_out    = 0;
    int         reg_writes    = 0;
    int         quiet_cycles  = 0;
    int         src_idle_pct  = 20;
    int         sink_idle_pct = 20;

    rgba_layer_blend_compositor u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] round_product(int t);
        return 8'((t + (t >> 8)) >> 8);
    endfunction

    function automatic logic [7:0] composite_channel(logic [3:0] m, logic [7:0] w,
                                                     logic [7:0] x, logic [7:0] y);
        int xi;
        int yi;
        int wi;
        int v;
        xi = int'(x);
        yi = int'(y);
        wi = int'(w);
        case (m)
            ModeAdd:      v = xi + yi;
            ModeSub:      v = xi - yi;
            ModeDiff:     v = (xi > yi) ? xi - yi : yi - xi;
            ModeDarken:   v = (xi < yi) ? xi : yi;
            ModeLighten:  v = (xi > yi) ? xi : yi;
            ModeMult:     v = int'(round_product(xi * yi + 128));
            ModeBlend:    v = int'(round_product(xi * (255 - wi) + yi * wi + 1));
            ModeScreen:   v = 255 - int'(round_product((255 - xi) * (255 - yi) + 128));
            ModeGmerge:   v = xi + yi - 128;
            ModeGextract: v = xi - yi + 128;
            ModeDivide:   v = (xi * 256) / (yi + 1);
            ModeDodge:    v = (xi * 256) / (256 - yi);
            default:      v = 0;
        endcase
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic out_t composite_pixel(logic [3:0] m, logic [7:0] w,
                                             logic [63:0] data, logic last);
        out_t r;
        r.red   = composite_channel(m, w, data[7:0], data[39:32]);
        r.green = composite_channel(m, w, data[15:8], data[47:40]);
        r.blue  = composite_channel(m, w, data[23:16], data[55:48]);
        if (m == ModeBlend)
            r.alpha = composite_channel(m, w, data[31:24], data[63:56]);
        else if (m > ModeDodge)
            r.alpha = 8'd0;
        else
            r.alpha = (data[31:24] < data[63:56]) ? data[31:24] : data[63:56];
        r.last = last;
        return r;
    endfunction

    function automatic logic [63:0] random_pair();
        logic [63:0] data;
        int          i;
        for (i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 7))
                0:       data[8*i +: 8] = 8'h00;
                1:       data[8*i +: 8] = 8'hff;
                2:       data[8*i +: 8] = 8'(127 + $urandom_range(0, 2));
                default: data[8*i +: 8] = 8'($urandom);
            endcase
        end
        return data;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= ReportLimit)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic send_pixel(input logic [63:0] data, input logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_registers(input logic [7:0] mode_word, input logic [7:0] weight,
                                 input bit stray);
        logic [7:0] idx [3];
        logic [7:0] val [3];
        int         n;
        int         i;
        drain_pipeline();
        idx[0] = CfgMode;
        val[0] = mode_word;
        idx[1] = CfgBlend;
        val[1] = weight;
        n      = 2;
        if (stray)
        begin
            idx[2] = 8'($urandom_range(CfgFirstUnused, 255));
            val[2] = 8'($urandom);
            n      = 3;
        end
        for (i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_pixel(CornerPair, 1'b0);
        send_pixel(MixedPair, 1'b1);
    endtask

    task automatic test_each_mode();
        int k;
        for (k = int'(ModeSub); k <= int'(ModeDodge); k++)
        begin
            set_registers({4'($urandom), 4'(k)}, 8'd128, 1'b0);
            send_pixel(CornerPair, k == int'(ModeDodge));
        end
    endtask

    task automatic test_unused_modes();
        set_registers({4'h0, ModeFirstUnused}, 8'd77, 1'b0);
        send_pixel(MixedPair, 1'b1);
        set_registers({4'hf, ModeLastUnused}, 8'd200, 1'b0);
        send_pixel(CornerPair, 1'b0);
    endtask

    task automatic test_blend_extremes();
        set_registers({4'h0, ModeBlend}, 8'd0, 1'b0);
        send_pixel(MixedPair, 1'b0);
        set_registers({4'h0, ModeBlend}, 8'd255, 1'b0);
        send_pixel(MixedPair, 1'b1);
    endtask

    task automatic test_stray_index();
        set_registers({4'h5, ModeDiff}, 8'd200, 1'b1);
        send_pixel(MixedPair, 1'b0);
    endtask

    task automatic test_random_phases();
        int         sent;
        int         phase;
        int         n;
        logic [3:0] m;
        logic [7:0] weight;
        sent  = 0;
        phase = 0;
        while (sent < RandomItems)
        begin
            if (phase < 16)
                m = 4'(phase);
            else if ($urandom_range(0, 5) == 0)
                m = 4'($urandom_range(ModeFirstUnused, ModeLastUnused));
            else
                m = 4'($urandom_range(ModeAdd, ModeDodge));
            case ($urandom_range(0, 3))
                0:       weight = 8'd0;
                1:       weight = 8'd255;
                default: weight = 8'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       src_idle_pct = 0;
                1:       src_idle_pct = 15;
                default: src_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_idle_pct = 0;
                1:       sink_idle_pct = 15;
                default: sink_idle_pct = 40;
            endcase
            set_registers({4'($urandom), m}, weight, $urandom_range(0, 3) == 0);
            n = $urandom_range(10, 50);
            repeat (n)
            begin
                send_pixel(random_pair(), $urandom_range(0, 7) == 0);
                sent++;
            end
            phase++;
        end
    endtask

    task automatic test_steady_stream();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_registers({4'($urandom), 4'($urandom_range(ModeAdd, ModeDodge))},
                      8'($urandom), 1'b0);
        repeat (SteadyItems)
            send_pixel(random_pair(), $urandom_range(0, 7) == 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                if (cfg_index == CfgMode)
                    model_mode = cfg_data[3:0];
                else if (cfg_index == CfgBlend)
                    model_weight = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                pixels_in++;
                modes_seen[model_mode] = 1'b1;
                expected_pixels.push_back(composite_pixel(model_mode, model_weight,
                                                          s_tdata, s_tlast));
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            pixels_out++;
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                $error("output word with no pixel pair waiting for it");
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("d_red", want.red, m_tdata[7:0]);
                check_field("d_green", want.green, m_tdata[15:8]);
                check_field("d_blue", want.blue, m_tdata[23:16]);
                check_field("d_alpha", want.alpha, m_tdata[31:24]);
                check_field("last_out", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $error("no word moved for %0d cycles", StallLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_mode();
        test_unused_modes();
        test_blend_extremes();
        test_stray_index();
        test_random_phases();
        test_steady_stream();

        drain_pipeline();
        repeat (20) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            error_count++;
            $error("%0d composited pixels never arrived", expected_pixels.size());
        end

        $display("Sent %0d pixel pairs and %0d register writes; mode codes used: %b",
                 pixels_in, reg_writes, modes_seen);
        $display("Checked %0d composited pixels with %0d field mismatches",
                 pixels_out, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rlbc_pkg.sv
hdl/rlbc_prep.sv
hdl/rlbc_div_stage.sv
hdl/rlbc_finish.sv
hdl/rgba_layer_blend_compositor.sv
hdl/rlbc_checker.sv
verif/rgba_layer_blend_compositor_tb.sv
